FILE: design/pcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the polar/Cartesian converter
// Fixed-point constants in Q.30, the per-stage rotation angles and the gain
// that cancels the rotation growth in advance.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // Conversion direction carried in tuser.
  localparam logic KIND_POL2CART = 1'b0;
  localparam logic KIND_CART2POL = 1'b1;

  // Internal angle and remainder widths (Q.30).
  localparam int ANGLE_BITS  = 35;
  localparam int REM_BITS    = 36;
  localparam int Q30_BITS    = 30;
  localparam int RECIP_SHIFT = 31;

  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint GAIN_BASE   = 64'sd652032874;
  localparam longint GAIN_TAIL   = 64'sd434688583;
  localparam longint OUT_MAX     = 64'sd2147483647;
  localparam longint OUT_MIN     = -64'sd2147483648;

  // Control that travels with every word down the pipeline.
  typedef struct packed {
    logic valid;
    logic kind;
    logic zero;
  } ctl_t;

  // atan(2^-idx) in Q.30.
  function automatic logic [29:0] stage_angle(input int unsigned idx);
    logic [29:0] ang;
    case (idx)
      0:       ang = 30'd843314857;
      1:       ang = 30'd497837829;
      2:       ang = 30'd263043837;
      3:       ang = 30'd133525159;
      4:       ang = 30'd67021687;
      5:       ang = 30'd33543516;
      6:       ang = 30'd16775851;
      7:       ang = 30'd8388437;
      8:       ang = 30'd4194283;
      9:       ang = 30'd2097149;
      10:      ang = 30'd1048576;
      default: ang = (idx <= 30) ? 30'(64'd1 << (30 - idx)) : 30'd0;
    endcase
    return ang;
  endfunction

  // Inverse of the rotation gain in Q.30; the tail term vanishes for long chains.
  function automatic longint gain_q30(input int stages);
    longint g;
    g = GAIN_BASE;
    if (stages < 16) begin
      g = g + (GAIN_TAIL >> (2 * stages));
    end
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: design/polar_cartesian_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polar_cartesian_converter: pipelined polar/Cartesian conversion
// Rotation mode gives x = r*cos(phi), y = r*sin(phi); vectoring mode gives
// r = sqrt(x*x + y*y) and phi in [0, pi]. All values are signed Q15.16.
//
//   channel   dir  tdata (low bits first)            tuser
//   s_axis    in   first_value, second_value (64)    kind (1)
//   m_axis    out  first_result, second_result (64)  saturated (1)
//
// One word is accepted every cycle while the skid register is empty; the
// pipeline is five scaling stages, one stage per rotation, a rounding stage
// and the output register. Reset clears all valid bits. When the output word is
// not taken, the next word parks in a skid register; only then does s_tready
// fall and the whole pipeline hold, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module polar_cartesian_converter #(
  parameter int ROTATION_STAGES = 18,
  parameter int FRACTION_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // first_value [31:0], second_value [63:32]
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // first_result [31:0], second_result [63:32]
  output logic             m_tuser    // saturated
);

  localparam int DW = 64 - FRACTION_BITS;
  localparam int ZW = pcc_pkg::ANGLE_BITS;

  logic ce;
  logic skid_valid;
  logic out_valid;

  assign ce       = !skid_valid;
  assign s_tready = ce;

  pcc_pkg::ctl_t        st_ctl [0:ROTATION_STAGES];
  logic signed [DW-1:0] st_x   [0:ROTATION_STAGES];
  logic signed [DW-1:0] st_y   [0:ROTATION_STAGES];
  logic signed [ZW-1:0] st_z   [0:ROTATION_STAGES];

  pcc_prep #(
    .FRACTION_BITS   (FRACTION_BITS),
    .ROTATION_STAGES (ROTATION_STAGES)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .a        (s_tdata[31:0]),
    .b        (s_tdata[63:32]),
    .ctl_q    (st_ctl[0]),
    .x_q      (st_x[0]),
    .y_q      (st_y[0]),
    .z_q      (st_z[0])
  );

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    pcc_stage #(
      .IDX (i),
      .DW  (DW)
    ) u_stage (
      .clk   (clk),
      .rst   (rst),
      .ce    (ce),
      .ctl   (st_ctl[i]),
      .x     (st_x[i]),
      .y     (st_y[i]),
      .z     (st_z[i]),
      .ctl_q (st_ctl[i+1]),
      .x_q   (st_x[i+1]),
      .y_q   (st_y[i+1]),
      .z_q   (st_z[i+1])
    );
  end

  logic        p_valid;
  logic [31:0] p_first, p_second;
  logic        p_sat;

  pcc_post #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .ctl      (st_ctl[ROTATION_STAGES]),
    .x        (st_x[ROTATION_STAGES]),
    .y        (st_y[ROTATION_STAGES]),
    .z        (st_z[ROTATION_STAGES]),
    .valid_q  (p_valid),
    .first_q  (p_first),
    .second_q (p_second),
    .sat_q    (p_sat)
  );

  // Output register with a one-word skid behind it.
  logic        take, incoming;
  logic        load_out, load_skid, out_from_skid;
  logic        out_valid_next, skid_valid_next;
  logic [31:0] out_first, out_second, skid_first, skid_second;
  logic        out_sat, skid_sat;

  always_comb begin
    take            = out_valid && m_tready;
    incoming        = ce && p_valid;
    load_out        = 1'b0;
    load_skid       = 1'b0;
    out_from_skid   = 1'b0;
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (skid_valid) begin
      if (take) begin
        load_out        = 1'b1;
        out_from_skid   = 1'b1;
        skid_valid_next = 1'b0;
      end
    end else if (incoming) begin
      if (out_valid && !take) begin
        load_skid       = 1'b1;
        skid_valid_next = 1'b1;
      end else begin
        load_out       = 1'b1;
        out_valid_next = 1'b1;
      end
    end else if (take) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_first  <= out_from_skid ? skid_first  : p_first;
      out_second <= out_from_skid ? skid_second : p_second;
      out_sat    <= out_from_skid ? skid_sat    : p_sat;
    end
    if (load_skid) begin
      skid_first  <= p_first;
      skid_second <= p_second;
      skid_sat    <= p_sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_second, out_first};
  assign m_tuser  = out_sat;

  // The skid register only ever holds a word behind a full output register.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word without an output word");

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid filled while the output was free");

  assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_tready |=> skid_valid && $stable(skid_first) && $stable(skid_second))
    else $error("parked word lost or changed during a stall");

endmodule
`default_nettype wire

FILE: design/pcc_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_prep: input scaling and angle reduction
// Five register stages: gain and reciprocal multiply, quotient multiply and
// quadrant swap, remainder, wrap into (-pi, pi], and half-pi fold.
// ----------------------------------------------------------------------------
module pcc_prep #(
  parameter int FRACTION_BITS   = 16,
  parameter int ROTATION_STAGES = 18,
  localparam int DW = 64 - FRACTION_BITS,
  localparam int ZW = pcc_pkg::ANGLE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 ce,
  input  wire logic                 in_valid,
  input  wire logic                 in_kind,
  input  wire logic signed [31:0]   a,
  input  wire logic signed [31:0]   b,
  output pcc_pkg::ctl_t             ctl_q,
  output logic signed [DW-1:0]      x_q,
  output logic signed [DW-1:0]      y_q,
  output logic signed [ZW-1:0]      z_q
);

  localparam int SHIFT = pcc_pkg::Q30_BITS - FRACTION_BITS;
  localparam int QW    = SHIFT + 2;
  localparam int RW    = pcc_pkg::REM_BITS;
  localparam longint GAIN  = pcc_pkg::gain_q30(ROTATION_STAGES);
  localparam longint RECIP = (64'sd1 <<< (pcc_pkg::RECIP_SHIFT + SHIFT)) / pcc_pkg::Q30_TWO_PI;

  localparam logic signed [30:0] GAIN_OP   = 31'(GAIN);
  localparam logic signed [30:0] RECIP_OP  = 31'(RECIP);
  localparam logic signed [33:0] TWO_PI_OP = 34'(pcc_pkg::Q30_TWO_PI);
  localparam logic signed [RW-1:0] PI_R     = RW'(pcc_pkg::Q30_PI);
  localparam logic signed [RW-1:0] NEG_PI_R = -RW'(pcc_pkg::Q30_PI);
  localparam logic signed [RW-1:0] PI3_R    = RW'(3 * pcc_pkg::Q30_PI);
  localparam logic signed [RW-1:0] TWO_PI_R = RW'(pcc_pkg::Q30_TWO_PI);
  localparam logic signed [ZW-1:0] PI_Z     = ZW'(pcc_pkg::Q30_PI);
  localparam logic signed [ZW-1:0] HP_Z     = ZW'(pcc_pkg::Q30_HALF_PI);
  localparam logic signed [ZW-1:0] NEG_HP_Z = -ZW'(pcc_pkg::Q30_HALF_PI);

  // Stage 1: products.
  pcc_pkg::ctl_t       c1;
  logic signed [63:0]  prod_a1, prod_b1;
  logic signed [31:0]  b1;
  logic signed [32:0]  b_ext, b_abs, mul_b_op;
  logic signed [30:0]  mul_b_k;
  logic                zero_in;

  always_comb begin
    b_ext    = {b[31], b};
    b_abs    = b[31] ? -b_ext : b_ext;
    mul_b_op = (in_kind == pcc_pkg::KIND_CART2POL) ? b_abs : b_ext;
    mul_b_k  = (in_kind == pcc_pkg::KIND_CART2POL) ? GAIN_OP : RECIP_OP;
    zero_in  = (a == 32'sd0) && (b == 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else if (ce) begin
      c1 <= '{valid: in_valid, kind: in_kind, zero: zero_in};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_a1 <= 64'(a) * 64'(GAIN_OP);
      prod_b1 <= 64'(mul_b_op) * 64'(mul_b_k);
      b1      <= b;
    end
  end

  // Stage 2: scale to Q.30, quotient times two pi, quadrant swap for vectoring.
  pcc_pkg::ctl_t       c2;
  logic signed [DW-1:0] x0, yv, x2, y2, x2_next, y2_next;
  logic signed [ZW-1:0] z2, z2_next;
  logic signed [QW-1:0] quo;
  logic signed [63:0]   qc2;
  logic signed [31:0]   b2;

  always_comb begin
    x0  = prod_a1[63:FRACTION_BITS];
    yv  = prod_b1[63:FRACTION_BITS];
    quo = prod_b1[pcc_pkg::RECIP_SHIFT +: QW];
    x2_next = x0;
    y2_next = '0;
    z2_next = '0;
    if (c1.kind == pcc_pkg::KIND_CART2POL) begin
      y2_next = yv;
      // A vector in the left half plane is turned by a quarter turn first.
      if (x0[DW-1]) begin
        x2_next = yv;
        y2_next = -x0;
        z2_next = HP_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
    end else if (ce) begin
      c2 <= c1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x2  <= x2_next;
      y2  <= y2_next;
      z2  <= z2_next;
      qc2 <= 64'(quo) * 64'(TWO_PI_OP);
      b2  <= b1;
    end
  end

  // Stage 3: remainder of the angle; the estimated quotient is off by at most one.
  pcc_pkg::ctl_t        c3;
  logic signed [DW-1:0] x3, y3;
  logic signed [ZW-1:0] z3;
  logic signed [RW-1:0] r3;
  logic signed [63:0]   t_full, r_full;

  always_comb begin
    t_full = 64'(b2) <<< SHIFT;
    r_full = t_full - qc2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3 <= '0;
    end else if (ce) begin
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x3 <= x2;
      y3 <= y2;
      z3 <= z2;
      r3 <= r_full[RW-1:0];
    end
  end

  // Stage 4: wrap the remainder from [-2pi, 4pi) into (-pi, pi].
  pcc_pkg::ctl_t        c4;
  logic signed [DW-1:0] x4, y4;
  logic signed [ZW-1:0] z4, z4_next;
  logic signed [RW-1:0] r_sel;

  always_comb begin
    if (r3 <= NEG_PI_R) begin
      r_sel = r3 + TWO_PI_R;
    end else if (r3 <= PI_R) begin
      r_sel = r3;
    end else if (r3 <= PI3_R) begin
      r_sel = r3 - TWO_PI_R;
    end else begin
      r_sel = r3 - TWO_PI_R - TWO_PI_R;
    end
    z4_next = (c3.kind == pcc_pkg::KIND_CART2POL) ? z3 : r_sel[ZW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4 <= '0;
    end else if (ce) begin
      c4 <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x4 <= x3;
      y4 <= y3;
      z4 <= z4_next;
    end
  end

  // Stage 5: fold angles beyond a quarter turn by flipping the start vector.
  logic signed [DW-1:0] x5_next;
  logic signed [ZW-1:0] z5_next;

  always_comb begin
    x5_next = x4;
    z5_next = z4;
    if (c4.kind == pcc_pkg::KIND_POL2CART) begin
      if (z4 > HP_Z) begin
        x5_next = -x4;
        z5_next = z4 - PI_Z;
      end else if (z4 < NEG_HP_Z) begin
        x5_next = -x4;
        z5_next = z4 + PI_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else if (ce) begin
      ctl_q <= c4;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_q <= x5_next;
      y_q <= y4;
      z_q <= z5_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/pcc_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_stage: one shift-and-add rotation stage
// Rotates toward zero angle (rotation) or toward the x axis (vectoring).
// ----------------------------------------------------------------------------
module pcc_stage #(
  parameter int IDX = 0,
  parameter int DW  = 48,
  localparam int ZW = pcc_pkg::ANGLE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 ce,
  input  wire pcc_pkg::ctl_t        ctl,
  input  wire logic signed [DW-1:0] x,
  input  wire logic signed [DW-1:0] y,
  input  wire logic signed [ZW-1:0] z,
  output pcc_pkg::ctl_t             ctl_q,
  output logic signed [DW-1:0]      x_q,
  output logic signed [DW-1:0]      y_q,
  output logic signed [ZW-1:0]      z_q
);

  localparam logic signed [ZW-1:0] ANG = ZW'(pcc_pkg::stage_angle(IDX));

  logic signed [DW-1:0] xs, ys;
  logic                 ccw;

  always_comb begin
    xs = x >>> IDX;
    ys = y >>> IDX;
    if (ctl.kind == pcc_pkg::KIND_CART2POL) begin
      ccw = y[DW-1] || (y == '0);
    end else begin
      ccw = !z[ZW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else if (ce) begin
      ctl_q <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (ccw) begin
        x_q <= x - ys;
        y_q <= y + xs;
        z_q <= z - ANG;
      end else begin
        x_q <= x + ys;
        y_q <= y - xs;
        z_q <= z + ANG;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/pcc_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_post: output rounding and saturation
// Rounds Q.30 results to the output format, clamps the vectoring angle to
// [0, pi] and clips coordinates and radius to 32 bits.
// ----------------------------------------------------------------------------
module pcc_post #(
  parameter int FRACTION_BITS = 16,
  localparam int DW = 64 - FRACTION_BITS,
  localparam int ZW = pcc_pkg::ANGLE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 ce,
  input  wire pcc_pkg::ctl_t        ctl,
  input  wire logic signed [DW-1:0] x,
  input  wire logic signed [DW-1:0] y,
  input  wire logic signed [ZW-1:0] z,
  output logic                      valid_q,
  output logic [31:0]               first_q,
  output logic [31:0]               second_q,
  output logic                      sat_q
);

  localparam int SHIFT = pcc_pkg::Q30_BITS - FRACTION_BITS;
  localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (SHIFT - 1);
  localparam logic signed [ZW-1:0] PI_Z = ZW'(pcc_pkg::Q30_PI);
  localparam logic signed [63:0] MAX_W = pcc_pkg::OUT_MAX;
  localparam logic signed [63:0] MIN_W = pcc_pkg::OUT_MIN;

  function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
    return (v + HALF_LSB) >>> SHIFT;
  endfunction

  logic signed [63:0]   xr, yr, zr;
  logic signed [ZW-1:0] zc;
  logic                 x_hi, x_lo, y_hi, y_lo;
  logic [31:0]          x_out, y_out, first_next, second_next;
  logic                 sat_next;

  always_comb begin
    xr = round_q30(64'(x));
    yr = round_q30(64'(y));
    if (z[ZW-1]) begin
      zc = '0;
    end else if (z > PI_Z) begin
      zc = PI_Z;
    end else begin
      zc = z;
    end
    zr   = round_q30(64'(zc));
    x_hi = xr > MAX_W;
    x_lo = xr < MIN_W;
    y_hi = yr > MAX_W;
    y_lo = yr < MIN_W;
    x_out = x_hi ? MAX_W[31:0] : (x_lo ? MIN_W[31:0] : xr[31:0]);
    y_out = y_hi ? MAX_W[31:0] : (y_lo ? MIN_W[31:0] : yr[31:0]);
    if (ctl.kind == pcc_pkg::KIND_CART2POL) begin
      first_next  = x_out;
      second_next = zr[31:0];
      sat_next    = x_hi || x_lo;
      // A zero vector has no direction; it reports radius 0 and angle 0.
      if (ctl.zero) begin
        first_next  = '0;
        second_next = '0;
        sat_next    = 1'b0;
      end
    end else begin
      first_next  = x_out;
      second_next = y_out;
      sat_next    = x_hi || x_lo || y_hi || y_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ce) begin
      valid_q <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      first_q  <= first_next;
      second_q <= second_next;
      sat_q    <= sat_next;
    end
  end

  // The vectoring angle is clamped before rounding and is never negative.
  assert property (@(posedge clk) disable iff (rst)
    ce && ctl.valid && (ctl.kind == pcc_pkg::KIND_CART2POL) |=> !second_q[31])
    else $error("vectoring angle came out negative");

endmodule
`default_nettype wire

FILE: dv/polar_cartesian_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_cartesian_checker: scoreboard for the polar/Cartesian converter
// Watches both stream channels and runs its own bit-exact shift-and-add
// model on every accepted input word. It keeps the predicted results in
// order, checks each output word field by field against the oldest one,
// and hands the mismatch count and the number of outstanding words to the
// testbench top.
// ----------------------------------------------------------------------------
module polar_cartesian_checker #(
  parameter int ROTATION_STAGES = 18,
  parameter int FRACTION_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // first_value [31:0], second_value [63:32]
  input  logic        s_tuser,   // kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // first_result [31:0], second_result [63:32]
  input  logic        m_tuser,   // saturated
  output int          mismatch_count,
  output int          pending
);

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint GAIN_TAIL   = 64'sd434688583;
  localparam longint OUT_MAX     = 64'sd2147483647;
  localparam longint OUT_MIN     = -64'sd2147483648;
  localparam int     OUT_SHIFT   = 30 - FRACTION_BITS;

  typedef struct packed {
    logic        kind;
    logic [31:0] first_in;
    logic [31:0] second_in;
    logic [31:0] first_out;
    logic [31:0] second_out;
    logic        clipped;
  } conversion_t;

  conversion_t conversions_due[$];
  conversion_t oldest;

  function automatic longint micro_angle(input int idx);
    case (idx)
      0:       return 64'sd843314857;
      1:       return 64'sd497837829;
      2:       return 64'sd263043837;
      3:       return 64'sd133525159;
      4:       return 64'sd67021687;
      5:       return 64'sd33543516;
      6:       return 64'sd16775851;
      7:       return 64'sd8388437;
      8:       return 64'sd4194283;
      9:       return 64'sd2097149;
      10:      return 64'sd1048576;
      default: return (idx <= 30) ? (longint'(1) << (30 - idx)) : 64'sd0;
    endcase
  endfunction

  // Input to Q.30 with the rotation growth already divided out.
  function automatic longint prescale(input longint v);
    longint g;
    g = GAIN_Q30;
    if (ROTATION_STAGES < 16) begin
      g = g + (GAIN_TAIL >>> (2 * ROTATION_STAGES));
    end
    return (v * g) >>> FRACTION_BITS;
  endfunction

  function automatic logic [31:0] round_to_fixed(input longint q, inout logic clip);
    longint v;
    v = (q + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (v > OUT_MAX) begin
      v    = OUT_MAX;
      clip = 1'b1;
    end else if (v < OUT_MIN) begin
      v    = OUT_MIN;
      clip = 1'b1;
    end
    return 32'(v);
  endfunction

  function automatic conversion_t convert(input logic kind, input logic [31:0] fv,
                                          input logic [31:0] sv);
    conversion_t c;
    longint a, b, x, y, z, nx, ny;
    int n;
    logic clip;
    a    = longint'($signed(fv));
    b    = longint'($signed(sv));
    clip = 1'b0;
    n    = (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;
    c.kind      = kind;
    c.first_in  = fv;
    c.second_in = sv;
    if (kind == pcc_pkg::KIND_POL2CART) begin
      x = prescale(a);
      y = 0;
      // Fold the angle into (-pi, pi], then into the right half plane.
      z = (b * (longint'(1) << OUT_SHIFT)) % TWO_PI_Q30;
      if (z < 0) z = z + TWO_PI_Q30;
      if (z > PI_Q30) z = z - TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
        x = -x;
        z = z - PI_Q30;
      end else if (z < -HALF_PI_Q30) begin
        x = -x;
        z = z + PI_Q30;
      end
      for (int i = 0; i < n; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - micro_angle(i);
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + micro_angle(i);
        end
        x = nx;
        y = ny;
      end
      c.first_out  = round_to_fixed(x, clip);
      c.second_out = round_to_fixed(y, clip);
    end else if (a == 0 && b == 0) begin
      c.first_out  = '0;
      c.second_out = '0;
    end else begin
      // Only |y| matters since the angle is reported as acos(x/r).
      x = prescale(a);
      y = prescale((b < 0) ? -b : b);
      z = 0;
      if (x < 0) begin
        nx = y;
        y  = -x;
        x  = nx;
        z  = HALF_PI_Q30;
      end
      for (int i = 0; i < n; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + micro_angle(i);
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - micro_angle(i);
        end
        x = nx;
        y = ny;
      end
      if (z < 0) z = 0;
      if (z > PI_Q30) z = PI_Q30;
      c.first_out  = round_to_fixed(x, clip);
      c.second_out = round_to_fixed(z, clip);
    end
    c.clipped = clip;
    return c;
  endfunction

  task automatic report(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (conversions_due.size() == 0) begin
          report($sformatf("output word %h/%b with nothing outstanding", m_tdata, m_tuser));
        end else begin
          oldest = conversions_due.pop_front();
          if (m_tdata[31:0] !== oldest.first_out) begin
            report($sformatf("first_result %h, expected %h (kind %0d in %h %h)",
                             m_tdata[31:0], oldest.first_out, oldest.kind,
                             oldest.first_in, oldest.second_in));
          end
          if (m_tdata[63:32] !== oldest.second_out) begin
            report($sformatf("second_result %h, expected %h (kind %0d in %h %h)",
                             m_tdata[63:32], oldest.second_out, oldest.kind,
                             oldest.first_in, oldest.second_in));
          end
          if (m_tuser !== oldest.clipped) begin
            report($sformatf("saturated %b, expected %b (kind %0d in %h %h)",
                             m_tuser, oldest.clipped, oldest.kind,
                             oldest.first_in, oldest.second_in));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        conversions_due.push_back(convert(s_tuser, s_tdata[31:0], s_tdata[63:32]));
      end
    end
    pending <= conversions_due.size();
  end

endmodule

FILE: dv/polar_cartesian_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_cartesian_converter_tb: stimulus and verdict for the converter
// Sends a directed set of corner vectors in both directions, then random
// polar and Cartesian words, with random idle bursts on both channels and
// one long output stall that backs the pipeline up. The checker module
// predicts and compares every output word.
// ----------------------------------------------------------------------------
module polar_cartesian_converter_tb;

  localparam int ROT_STAGES   = 18;
  localparam int FRAC_BITS    = 16;
  localparam int LATENCY      = ROT_STAGES + 7;
  localparam int RANDOM_WORDS = 1230;
  localparam int CALM_WORDS   = 150;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ONE_Q16      = 65536;
  localparam int PI_Q16       = 205887;
  localparam int HALF_PI_Q16  = 102944;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  int mismatch_count;
  int pending;
  int cycle_count = 0;
  bit squeeze = 0;
  bit squeeze_done = 0;
  bit calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  polar_cartesian_converter #(
    .ROTATION_STAGES(ROT_STAGES),
    .FRACTION_BITS  (FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  polar_cartesian_checker #(
    .ROTATION_STAGES(ROT_STAGES),
    .FRACTION_BITS  (FRAC_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] signed_span(input int span);
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Radius or coordinate: zero, full range, near the extremes, or moderate.
  function automatic logic [31:0] draw_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return $urandom;
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 4095)
                                           : 32'h8000_0000 + $urandom_range(0, 4095);
      4:       return signed_span(ONE_Q16);
      default: return signed_span(1 << 22);
    endcase
  endfunction

  // Holds the word until the handshake; tvalid stays high on return.
  task automatic send_word(input logic kind, input logic [31:0] fv, input logic [31:0] sv);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {sv, fv};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Output side: random stall bursts, one long hold on request, none when calm.
  initial begin
    wait (!rst);
    forever begin
      if (squeeze && !squeeze_done) begin
        squeeze_done = 1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic        kind;
    logic [31:0] fv;
    logic [31:0] sv;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rotation corners: full-scale radius, exact quadrant angles, negative
    // radius, zero radius and the extreme angle codes.
    send_word(pcc_pkg::KIND_POL2CART, 32'h7FFF_FFFF, 32'd0);
    send_word(pcc_pkg::KIND_POL2CART, 32'h8000_0000, 32'd0);
    send_word(pcc_pkg::KIND_POL2CART, 32'h7FFF_FFFF, PI_Q16 / 4);
    send_word(pcc_pkg::KIND_POL2CART, ONE_Q16, HALF_PI_Q16);
    send_word(pcc_pkg::KIND_POL2CART, ONE_Q16, -HALF_PI_Q16);
    maybe_pause();
    send_word(pcc_pkg::KIND_POL2CART, ONE_Q16, PI_Q16);
    send_word(pcc_pkg::KIND_POL2CART, ONE_Q16, -PI_Q16);
    send_word(pcc_pkg::KIND_POL2CART, -3 * ONE_Q16, ONE_Q16);
    send_word(pcc_pkg::KIND_POL2CART, 32'd0, 32'd12345);
    send_word(pcc_pkg::KIND_POL2CART, 100 * ONE_Q16, 32'h7FFF_FFFF);
    send_word(pcc_pkg::KIND_POL2CART, 100 * ONE_Q16, 32'h8000_0000);
    send_word(pcc_pkg::KIND_POL2CART, 32'h8000_0000, PI_Q16);
    // Vectoring corners: zero vector, saturating radius, the axes and the
    // left half plane.
    send_word(pcc_pkg::KIND_CART2POL, 32'd0, 32'd0);
    send_word(pcc_pkg::KIND_CART2POL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(pcc_pkg::KIND_CART2POL, 32'h8000_0000, 32'h8000_0000);
    maybe_pause();
    send_word(pcc_pkg::KIND_CART2POL, -ONE_Q16, 32'd0);
    send_word(pcc_pkg::KIND_CART2POL, 32'd0, ONE_Q16);
    send_word(pcc_pkg::KIND_CART2POL, 32'd0, -ONE_Q16);
    send_word(pcc_pkg::KIND_CART2POL, ONE_Q16, 32'd0);
    send_word(pcc_pkg::KIND_CART2POL, ONE_Q16, -ONE_Q16);
    send_word(pcc_pkg::KIND_CART2POL, -5 * ONE_Q16, -2 * ONE_Q16);
    send_word(pcc_pkg::KIND_CART2POL, 32'hFFFF_FFFF, 32'd1);
    maybe_pause();

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == 60) squeeze = 1;
      if (k == RANDOM_WORDS - CALM_WORDS) calm = 1;
      kind = 1'($urandom_range(0, 1));
      fv   = draw_coord();
      if (kind == pcc_pkg::KIND_POL2CART) begin
        case ($urandom_range(0, 9))
          0, 1:    sv = $urandom;
          2:       sv = 32'(HALF_PI_Q16 * (int'($urandom_range(0, 16)) - 8));
          default: sv = signed_span(1 << 21);
        endcase
      end else begin
        sv = draw_coord();
      end
      send_word(kind, fv, sv);
      maybe_pause();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
